// ----- design/savl_pkg.sv -----
`default_nettype none

package savl_pkg;

    localparam int CELLS_PER_LINE = 40;
    localparam int COL_W          = 6;
    localparam int LINE_W         = 8;
    localparam int ADDR_W         = 16;
    localparam int COLOR_W        = 3;
    localparam int PIX_W          = 6;
    localparam int SLOT_W         = 3;

    localparam logic [ADDR_W-1:0] HIRES_BASE    = 16'hA000;
    localparam logic [ADDR_W-1:0] TEXT_BASE     = 16'hBB80;
    localparam logic [ADDR_W-1:0] HIRES_CHARSET = 16'h9800;
    localparam logic [ADDR_W-1:0] TEXT_CHARSET  = 16'hB400;
    localparam logic [ADDR_W-1:0] ALT_SET_OFS   = 16'(128 * 8);
    localparam logic [LINE_W-1:0] HIRES_LINES   = 8'd200;

    localparam logic [COLOR_W-1:0] INK_START   = 3'd7;
    localparam logic [COLOR_W-1:0] PAPER_START = 3'd0;

    // slot of the last pixel of a cell and of the trailing read request
    localparam logic [SLOT_W-1:0] SLOT_LAST_PIX = 3'd5;
    localparam logic [SLOT_W-1:0] SLOT_REQ      = 3'd6;

    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_DATA  = 1'b1;
    localparam logic KIND_REQ   = 1'b0;
    localparam logic KIND_PIXEL = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_SCREEN = 2'd1,
        PH_GLYPH  = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        ATTR_INK   = 2'b00,
        ATTR_TEXT  = 2'b01,
        ATTR_PAPER = 2'b10,
        ATTR_MODE  = 2'b11
    } attr_t;

    typedef enum logic {
        BATCH_REQ  = 1'b0,
        BATCH_CELL = 1'b1
    } batch_t;

    // one accepted word's worth of results
    typedef struct packed {
        batch_t               batch;
        logic [ADDR_W-1:0]    address;
        logic [PIX_W-1:0]     bits;
        logic [COLOR_W-1:0]   ink;
        logic [COLOR_W-1:0]   paper;
        logic                 inv;
        logic                 last_cell;
    } batch_desc_t;

endpackage

`default_nettype wire

// ----- design/savl_core.sv -----
`default_nettype none

module savl_core
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          accept,
    input  wire logic                          func,
    input  wire logic [savl_pkg::LINE_W-1:0]   line,
    input  wire logic [7:0]                    read_data,
    output logic                               load,
    output savl_pkg::batch_desc_t              desc
);

    savl_pkg::phase_t                  phase_reg, phase_next;
    logic [2:0]                        video_mode_reg, video_mode_next;
    logic [2:0]                        text_mode_reg, text_mode_next;
    logic [savl_pkg::COLOR_W-1:0]      ink_reg, ink_next;
    logic [savl_pkg::COLOR_W-1:0]      paper_reg, paper_next;
    logic [savl_pkg::COL_W-1:0]        column_reg, column_next;
    logic [savl_pkg::ADDR_W-1:0]       row_base_reg, row_base_next;
    logic [savl_pkg::LINE_W-1:0]       line_reg, line_next;
    logic                              cell_inv_reg, cell_inv_next;

    logic                              hires;
    logic [savl_pkg::COL_W:0]          col_inc;
    logic                              last_cell;
    logic                              is_cell;
    logic [savl_pkg::PIX_W-1:0]        cell_bits;
    logic                              cell_inv;
    logic [savl_pkg::ADDR_W-1:0]       glyph_addr;

    function automatic logic [savl_pkg::ADDR_W-1:0] row_base_f(
        input logic                        hires_mode,
        input logic [savl_pkg::LINE_W-1:0] ln
    );
        logic [savl_pkg::ADDR_W-1:0] stride;
        stride = savl_pkg::ADDR_W'(savl_pkg::CELLS_PER_LINE);
        if (hires_mode && (ln < savl_pkg::HIRES_LINES))
            return savl_pkg::HIRES_BASE + savl_pkg::ADDR_W'(ln) * stride;
        else
            return savl_pkg::TEXT_BASE + savl_pkg::ADDR_W'(ln >> 3) * stride;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= savl_pkg::PH_IDLE;
            video_mode_reg <= '0;
            text_mode_reg  <= '0;
            ink_reg        <= savl_pkg::INK_START;
            paper_reg      <= savl_pkg::PAPER_START;
            column_reg     <= '0;
            row_base_reg   <= '0;
            line_reg       <= '0;
            cell_inv_reg   <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            video_mode_reg <= video_mode_next;
            text_mode_reg  <= text_mode_next;
            ink_reg        <= ink_next;
            paper_reg      <= paper_next;
            column_reg     <= column_next;
            row_base_reg   <= row_base_next;
            line_reg       <= line_next;
            cell_inv_reg   <= cell_inv_next;
        end
    end

    assign hires     = video_mode_reg[2] && (line_reg < savl_pkg::HIRES_LINES);
    assign col_inc   = {1'b0, column_reg} + 7'd1;
    assign last_cell = col_inc >= 7'(savl_pkg::CELLS_PER_LINE);

    always_comb
    begin
        glyph_addr = video_mode_reg[2] ? savl_pkg::HIRES_CHARSET : savl_pkg::TEXT_CHARSET;
        if (text_mode_reg[0])
            glyph_addr = glyph_addr + savl_pkg::ALT_SET_OFS;
        glyph_addr = glyph_addr + {6'd0, read_data[6:0], 3'd0} + {13'd0, line_reg[2:0]};
    end

    always_comb
    begin
        phase_next      = phase_reg;
        video_mode_next = video_mode_reg;
        text_mode_next  = text_mode_reg;
        ink_next        = ink_reg;
        paper_next      = paper_reg;
        column_next     = column_reg;
        row_base_next   = row_base_reg;
        line_next       = line_reg;
        cell_inv_next   = cell_inv_reg;
        load            = 1'b0;
        is_cell         = 1'b0;
        cell_bits       = '0;
        cell_inv        = 1'b0;
        desc            = '0;
        desc.batch      = savl_pkg::BATCH_REQ;

        if (accept)
        begin
            if (func == savl_pkg::FUNC_START)
            begin
                line_next      = line;
                ink_next       = savl_pkg::INK_START;
                paper_next     = savl_pkg::PAPER_START;
                text_mode_next = '0;
                column_next    = '0;
                row_base_next  = row_base_f(video_mode_reg[2], line);
                desc.address   = row_base_next;
                load           = 1'b1;
                phase_next     = savl_pkg::PH_SCREEN;
            end
            else
            begin
                case (phase_reg)
                    savl_pkg::PH_SCREEN:
                    begin
                        cell_inv = read_data[7];
                        if (read_data[6:5] == 2'b00)
                        begin
                            // attribute cell: six paper pixels
                            is_cell = 1'b1;
                            case (savl_pkg::attr_t'(read_data[4:3]))
                                savl_pkg::ATTR_INK:   ink_next       = read_data[2:0];
                                savl_pkg::ATTR_TEXT:  text_mode_next = read_data[2:0];
                                savl_pkg::ATTR_PAPER: paper_next     = read_data[2:0];
                                savl_pkg::ATTR_MODE:
                                begin
                                    video_mode_next = read_data[2:0];
                                    row_base_next   = row_base_f(read_data[2], line_reg);
                                end
                                default: ;
                            endcase
                        end
                        else if (hires)
                        begin
                            is_cell   = 1'b1;
                            cell_bits = read_data[5:0];
                        end
                        else
                        begin
                            cell_inv_next = read_data[7];
                            desc.address  = glyph_addr;
                            load          = 1'b1;
                            phase_next    = savl_pkg::PH_GLYPH;
                        end
                    end
                    savl_pkg::PH_GLYPH:
                    begin
                        is_cell   = 1'b1;
                        cell_bits = read_data[5:0];
                        cell_inv  = cell_inv_reg;
                    end
                    default: ;
                endcase
            end
        end

        if (is_cell)
        begin
            load           = 1'b1;
            desc.batch     = savl_pkg::BATCH_CELL;
            desc.bits      = cell_bits;
            desc.ink       = ink_next;
            desc.paper     = paper_next;
            desc.inv       = cell_inv;
            desc.last_cell = last_cell;
            desc.address   = row_base_next + savl_pkg::ADDR_W'(col_inc);
            if (last_cell)
            begin
                column_next = '0;
                phase_next  = savl_pkg::PH_IDLE;
            end
            else
            begin
                column_next = col_inc[savl_pkg::COL_W-1:0];
                phase_next  = savl_pkg::PH_SCREEN;
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/savl_emit.sv -----
`default_nettype none

module savl_emit
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          load,
    input  wire savl_pkg::batch_desc_t         desc,
    output logic                               free,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [23:0]                        m_tdata,
    output logic                               m_tuser,
    output logic                               m_tlast
);

    logic                              desc_valid_reg, desc_valid_next;
    savl_pkg::batch_desc_t             desc_reg, desc_next;
    logic [savl_pkg::SLOT_W-1:0]       slot_reg, slot_next;

    logic                              is_req;
    logic                              last_now;
    logic                              take;
    logic                              done;
    logic                              eol;
    logic [savl_pkg::COLOR_W-1:0]      color;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            desc_valid_reg <= 1'b0;
            slot_reg       <= '0;
        end
        else
        begin
            desc_valid_reg <= desc_valid_next;
            slot_reg       <= slot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        desc_reg <= desc_next;
    end

    assign is_req   = (desc_reg.batch == savl_pkg::BATCH_REQ) || (slot_reg == savl_pkg::SLOT_REQ);
    assign eol      = desc_reg.last_cell && (slot_reg == savl_pkg::SLOT_LAST_PIX) && !is_req;
    assign last_now = is_req || eol;
    assign take     = desc_valid_reg && m_tready;
    assign done     = take && last_now;
    assign free     = !desc_valid_reg || done;

    always_comb
    begin
        desc_valid_next = desc_valid_reg;
        desc_next       = desc_reg;
        slot_next       = slot_reg;
        if (load)
        begin
            desc_valid_next = 1'b1;
            desc_next       = desc;
            slot_next       = '0;
        end
        else if (done)
        begin
            desc_valid_next = 1'b0;
            slot_next       = '0;
        end
        else if (take)
        begin
            slot_next = slot_reg + 3'd1;
        end
    end

    // pixels go out msb first
    assign color = desc_reg.bits[savl_pkg::SLOT_LAST_PIX - slot_reg] ? desc_reg.ink
                                                                     : desc_reg.paper;

    always_comb
    begin
        m_tvalid = desc_valid_reg;
        m_tlast  = last_now;
        m_tdata  = '0;
        if (is_req)
        begin
            m_tuser       = savl_pkg::KIND_REQ;
            m_tdata[15:0] = desc_reg.address;
        end
        else
        begin
            m_tuser        = savl_pkg::KIND_PIXEL;
            m_tdata[18:16] = color;
            m_tdata[19]    = desc_reg.inv;
            m_tdata[20]    = eol;
        end
    end

endmodule

`default_nettype wire

// ----- design/serial_attribute_video_line.sv -----
// Serial attribute text / hires video line generator.
//
// Slave channel: tuser = func (0 start line, 1 read data back), tdata carries
// the line number (start) or the byte read at the last requested address.
// Master channel: tuser = kind (0 read request, 1 pixel), tdata carries the
// address of a request, or the color index, inverse flag and end-of-line
// flag of a pixel; tlast marks the last result of each input word.
// A start word gives one request; a screen byte gives either one glyph
// request or a cell, and a glyph byte gives a cell; a cell is six pixels
// followed by the next screen request (seven words, six on the last cell).
// Latency: the first result of a word is shown the cycle after it is taken.
// Throughput: one result word per cycle while the receiver is ready; a new
// input word is taken in the same cycle that the last result of the previous
// one is taken, since the single result descriptor register serializes a
// word's results.
// Reset: ink 7, paper 0, all modes cleared, idle and nothing pending.
// While the receiver stalls the current result holds and no input is taken.
`default_nettype none

module serial_attribute_video_line
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [7:0] line, [15:8] read_data
    input  wire logic        s_tuser,   // [0] func
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [15:0] address, [18:16] color_index,
                                        // [19] inverse, [20] end_of_line
    output logic             m_tuser,   // [0] kind
    output logic             m_tlast
);

    logic                   accept;
    logic                   load;
    logic                   free;
    savl_pkg::batch_desc_t  desc;

    assign s_tready = free;
    assign accept   = s_tvalid && free;

    savl_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .func      (s_tuser),
        .line      (s_tdata[7:0]),
        .read_data (s_tdata[15:8]),
        .load      (load),
        .desc      (desc)
    );

    savl_emit u_emit
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .desc     (desc),
        .free     (free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

// ----- design/savl_checker.sv -----
`default_nettype none

module savl_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [15:0] s_tdata,
    input wire logic        s_tuser,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic        m_tuser,
    input wire logic        m_tlast
);

    // a stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled result word changed");

    // input is taken only when no result is pending or the last one leaves
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !m_tvalid || (m_tready && m_tlast))
        else $error("input taken while results pending");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == savl_pkg::KIND_REQ |-> m_tdata[23:16] == 8'd0 && m_tlast)
        else $error("request word carries pixel fields or is not last");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == savl_pkg::KIND_PIXEL |-> m_tdata[15:0] == 16'd0)
        else $error("pixel word carries an address");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[20] |-> m_tuser == savl_pkg::KIND_PIXEL && m_tlast)
        else $error("end of line not on last pixel word");

endmodule

bind serial_attribute_video_line savl_checker u_chk (.*);

`default_nettype wire
